/* rtl/sti_pkg.sv */
// Shared widths, constants, types and helpers for the sub-tick time interpolator.
// Used by sti_div, subtick_time_interpolator and sti_chk; no dependencies.
package sti_pkg;

    localparam int CNT_W     = 64;  // cycle counter
    localparam int RATE_W    = 34;  // counter_rate_hz
    localparam int TICK_W    = 20;  // tick_us
    localparam int USEC_W    = 20;  // kept_microseconds
    localparam int SEC_W     = 32;  // seconds
    localparam int NS_W      = 30;  // nanoseconds within a second
    localparam int TOTAL_W   = NS_W + 1;
    localparam int PERUS_W   = 15;  // counts per microsecond, below 17180
    localparam int LIMIT_W   = PERUS_W + TICK_W;
    localparam int KILO_W    = 10;
    localparam int NUM_W     = LIMIT_W + KILO_W;  // dividend
    localparam int QUO_W     = 30;  // quotient never exceeds tick_us * 1000

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = RATE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK = 1'd1;

    localparam logic [TICK_W-1:0] TICK_RESET = 20'd10000;
    localparam logic [NS_W-1:0]   CAP_RESET  = 30'd10000000;

    localparam logic [KILO_W-1:0]  KILO       = 10'd1000;
    localparam logic [TOTAL_W-1:0] NS_PER_SEC = 31'd1000000000;
    localparam logic [TOTAL_W-1:0] NS_TWO_SEC = 31'd2000000000;

    localparam int S_DATA_W = 184;  // 180 bits of fields, padded to bytes
    localparam int M_DATA_W = 64;   // 62 bits of fields, padded to bytes

    // rate / 1e6 = (rate >> 6) / 15625, done as a reciprocal multiply that is
    // exact for every 28-bit value
    localparam int PROD_W = 57;
    localparam int RECIP_SHIFT = 42;
    localparam logic [28:0] PER_US_RECIP = 29'd281474977;

    localparam int DIV_STEPS_DEFAULT = 3;

    typedef struct packed {
        logic [SEC_W-1:0] sec;
        logic [NS_W-1:0]  usec_ns;
    } meta_t;

    function automatic logic [PERUS_W-1:0] rate_to_per_us(input logic [RATE_W-1:0] rate);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(rate[RATE_W-1:6]) * PROD_W'(PER_US_RECIP);
        return prod[RECIP_SHIFT +: PERUS_W];
    endfunction

endpackage

/* rtl/subtick_time_interpolator.sv */
// Top level of the sub-tick time interpolator: config registers, front-end
// pipeline, sti_div divider, and the carry/normalize tail. Uses sti_pkg, sti_div.
//
//  Channel  Direction  Handshake           Payload
//  s_       in         s_tvalid/s_tready   s_tdata: counter_now, tick_anchor,
//                                          kept_seconds, kept_microseconds
//  m_       out        m_tvalid/m_tready   m_tdata: seconds_out, nanoseconds_out
//  cfg_     in         cfg_we              cfg_index, cfg_wdata
//
// One request per cycle sustained while m_tready keeps the output moving. Requests
// pass the front-end stages, the sti_div stages and the carry/normalize tail.
// Each stage moves when it is empty or the one after it moves, so bubbles close up
// and requests keep entering while a result waits on m_tready.
// aresetn (synchronous) clears all valid bits and the config registers
// (rate 0, tick 10000 us).
module subtick_time_interpolator #(
    parameter int DIV_STEPS = sti_pkg::DIV_STEPS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [63:0] counter_now, [127:64] tick_anchor, [159:128] kept_seconds,
    // [179:160] kept_microseconds, [183:180] zero
    input  logic [sti_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] seconds_out, [61:32] nanoseconds_out, [63:62] zero
    output logic [sti_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           cfg_we,
    input  logic [sti_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sti_pkg::CFG_DAT_W-1:0]  cfg_wdata
);

    // config: kept in the derived form the datapath needs
    logic [sti_pkg::PERUS_W-1:0] per_us_reg;
    logic [sti_pkg::TICK_W-1:0]  tick_reg;
    logic [sti_pkg::NS_W-1:0]    cap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            per_us_reg <= '0;
            tick_reg   <= sti_pkg::TICK_RESET;
            cap_reg    <= sti_pkg::CAP_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                sti_pkg::CFG_RATE: begin
                    per_us_reg <= sti_pkg::rate_to_per_us(cfg_wdata);
                end
                sti_pkg::CFG_TICK: begin
                    tick_reg <= cfg_wdata[sti_pkg::TICK_W-1:0];
                    cap_reg  <= sti_pkg::NS_W'(cfg_wdata[sti_pkg::TICK_W-1:0])
                                * sti_pkg::NS_W'(sti_pkg::KILO);
                end
                default: begin
                end
            endcase
        end
    end

    // input fields
    logic [sti_pkg::CNT_W-1:0]  in_now;
    logic [sti_pkg::CNT_W-1:0]  in_anchor;
    logic [sti_pkg::SEC_W-1:0]  in_sec;
    logic [sti_pkg::USEC_W-1:0] in_usec;

    assign in_now    = s_tdata[63:0];
    assign in_anchor = s_tdata[127:64];
    assign in_sec    = s_tdata[159:128];
    assign in_usec   = s_tdata[179:160];

    // stage enables
    logic en1, en2, en3, en4, en5;
    logic div_in_ready, div_out_valid;

    // stage 1: elapsed counts, tick limit, kept microseconds in ns
    logic                         v1_reg;
    logic [sti_pkg::CNT_W-1:0]    elapsed_reg;
    logic [sti_pkg::LIMIT_W-1:0]  limit_reg;
    sti_pkg::meta_t               meta1_reg;

    // stage 2: clamp
    logic                         v2_reg;
    logic [sti_pkg::LIMIT_W-1:0]  clamp_reg;
    sti_pkg::meta_t               meta2_reg;

    // stage 3: dividend
    logic                         v3_reg;
    logic [sti_pkg::NUM_W-1:0]    num_reg;
    sti_pkg::meta_t               meta3_reg;

    // stage 4: sum
    logic                         v4_reg;
    logic [sti_pkg::TOTAL_W-1:0]  total_reg;
    logic [sti_pkg::SEC_W-1:0]    sec4_reg;

    // stage 5: output register
    logic                         v5_reg;
    logic [sti_pkg::SEC_W-1:0]    sec_out_reg;
    logic [sti_pkg::NS_W-1:0]     ns_out_reg;

    logic [sti_pkg::QUO_W-1:0]    div_quo;
    sti_pkg::meta_t               div_meta;

    assign en5 = !v5_reg || m_tready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || div_in_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= div_out_valid;
            if (en5) v5_reg <= v4_reg;
        end
    end

    logic [sti_pkg::LIMIT_W-1:0] clamp_next;
    logic [sti_pkg::NS_W-1:0]    sub_ns;
    logic [sti_pkg::TOTAL_W-1:0] norm_ns;
    logic [1:0]                  carry;

    // counter behind anchor wraps; zero tick gives a zero limit
    assign clamp_next = (elapsed_reg > sti_pkg::CNT_W'(limit_reg))
                        ? limit_reg : elapsed_reg[sti_pkg::LIMIT_W-1:0];

    // uncalibrated counter: no sub-tick part; else quotient capped at tick_us * 1000
    always_comb begin
        if (per_us_reg == '0) begin
            sub_ns = '0;
        end else if (div_quo > cap_reg) begin
            sub_ns = cap_reg;
        end else begin
            sub_ns = div_quo;
        end
    end

    // sum stays below three seconds
    always_comb begin
        if (total_reg >= sti_pkg::NS_TWO_SEC) begin
            carry   = 2'd2;
            norm_ns = total_reg - sti_pkg::NS_TWO_SEC;
        end else if (total_reg >= sti_pkg::NS_PER_SEC) begin
            carry   = 2'd1;
            norm_ns = total_reg - sti_pkg::NS_PER_SEC;
        end else begin
            carry   = 2'd0;
            norm_ns = total_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            elapsed_reg       <= in_now - in_anchor;
            limit_reg         <= sti_pkg::LIMIT_W'(per_us_reg) * sti_pkg::LIMIT_W'(tick_reg);
            meta1_reg.sec     <= in_sec;
            meta1_reg.usec_ns <= sti_pkg::NS_W'(in_usec) * sti_pkg::NS_W'(sti_pkg::KILO);
        end
        if (en2) begin
            clamp_reg <= clamp_next;
            meta2_reg <= meta1_reg;
        end
        if (en3) begin
            num_reg   <= sti_pkg::NUM_W'(clamp_reg) * sti_pkg::NUM_W'(sti_pkg::KILO);
            meta3_reg <= meta2_reg;
        end
        if (en4) begin
            total_reg <= sti_pkg::TOTAL_W'(div_meta.usec_ns) + sti_pkg::TOTAL_W'(sub_ns);
            sec4_reg  <= div_meta.sec;
        end
        if (en5) begin
            sec_out_reg <= sec4_reg + sti_pkg::SEC_W'(carry);
            ns_out_reg  <= norm_ns[sti_pkg::NS_W-1:0];
        end
    end

    sti_div #(
        .STEPS(DIV_STEPS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v3_reg),
        .in_ready  (div_in_ready),
        .in_num    (num_reg),
        .in_meta   (meta3_reg),
        .divisor   (per_us_reg),
        .out_valid (div_out_valid),
        .out_ready (en4),
        .out_quo   (div_quo),
        .out_meta  (div_meta)
    );

    assign m_tvalid = v5_reg;
    assign m_tdata  = {2'b00, ns_out_reg, sec_out_reg};

endmodule

/* rtl/sti_div.sv */
// Pipelined restoring divider: dividend / counts-per-microsecond, STEPS
// quotient bits per stage, with side data carried alongside. Uses sti_pkg.
module sti_div #(
    parameter int STEPS = sti_pkg::DIV_STEPS_DEFAULT  // quotient bits per stage, 1..15
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [sti_pkg::NUM_W-1:0]    in_num,
    input  sti_pkg::meta_t               in_meta,
    input  logic [sti_pkg::PERUS_W-1:0]  divisor,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [sti_pkg::QUO_W-1:0]    out_quo,
    output sti_pkg::meta_t               out_meta
);

    localparam int STAGES = (sti_pkg::QUO_W + STEPS - 1) / STEPS;
    localparam int QB     = STAGES * STEPS;  // quotient bits produced
    localparam int RW     = sti_pkg::PERUS_W;

    logic            v_reg    [STAGES];
    logic [QB-1:0]   lq_reg   [STAGES];  // dividend low bits shift out, quotient bits in
    sti_pkg::meta_t  meta_reg [STAGES];
    logic [RW-1:0]   rem_reg  [STAGES-1];
    logic            en       [STAGES];

    assign in_ready  = en[0];
    assign out_valid = v_reg[STAGES-1];
    assign out_quo   = lq_reg[STAGES-1][sti_pkg::QUO_W-1:0];
    assign out_meta  = meta_reg[STAGES-1];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic           v_in;
        logic [RW-1:0]  rem_in;
        logic [QB-1:0]  lq_in;
        sti_pkg::meta_t meta_in;
        logic [RW-1:0]  rem_next;
        logic [QB-1:0]  lq_next;

        if (k == 0) begin : g_first
            // dividend < divisor * 2^QB, so the top part is already below divisor
            assign v_in    = in_valid;
            assign rem_in  = RW'(in_num >> QB);
            assign lq_in   = QB'(in_num);
            assign meta_in = in_meta;
        end else begin : g_mid
            assign v_in    = v_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign lq_in   = lq_reg[k-1];
            assign meta_in = meta_reg[k-1];
        end

        if (k == STAGES - 1) begin : g_en_last
            assign en[k] = !v_reg[k] || out_ready;
        end else begin : g_en_mid
            assign en[k] = !v_reg[k] || en[k+1];
        end

        always_comb begin
            logic [RW:0] trial;
            logic        ge;
            rem_next = rem_in;
            lq_next  = lq_in;
            for (int j = 0; j < STEPS; j++) begin
                trial = {rem_next, lq_next[QB-1]};
                ge    = trial >= {1'b0, divisor};
                if (ge) begin
                    rem_next = RW'(trial - {1'b0, divisor});
                end else begin
                    rem_next = trial[RW-1:0];
                end
                lq_next = {lq_next[QB-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en[k]) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                lq_reg[k]   <= lq_next;
                meta_reg[k] <= meta_in;
            end
        end

        if (k < STAGES - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en[k]) begin
                    rem_reg[k] <= rem_next;
                end
            end
        end
    end

endmodule

/* rtl/sti_chk.sv */
// Port-level checker for the sub-tick time interpolator, bound to the top level.
// Uses sti_pkg for widths and the nanosecond bound.
module sti_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [sti_pkg::S_DATA_W-1:0]  s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sti_pkg::M_DATA_W-1:0]  m_tdata
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // nanoseconds are always normalized
    a_ns_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[61:32] < sti_pkg::NS_W'(sti_pkg::NS_PER_SEC)))
        else $error("nanoseconds not below one second");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[63:62] == 2'b00)
        else $error("tdata padding not zero");

    // with the output free the whole pipeline moves, so input must be ready
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready || !m_tvalid |-> s_tready)
        else $error("input stalled with output free");

    // no result can show up right after reset with nothing requested
    a_no_phantom: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind subtick_time_interpolator sti_chk u_sti_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
